// ----- hw/rtl/msc_pkg.sv -----
// msc_pkg: shared types, constants and codes for the max-spacing clustering block
// used by every module under hw/rtl except msc_ram; depends on nothing else
package msc_pkg;

    // forest geometry
    localparam int MAX_NODES   = 1024;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int VERTEX_BITS = 10;
    localparam int COUNT_BITS  = 11;
    localparam int SIZE_BITS   = 11;
    localparam int COST_BITS   = 16;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 11;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE_COUNT      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_CLUSTERS = 1'd1;

    // register reset values
    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 11'd1024;
    localparam logic [COUNT_BITS-1:0] TARGET_RESET     = 11'd4;
    localparam logic [COUNT_BITS-1:0] MAX_NODES_COUNT  = COUNT_BITS'(MAX_NODES);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET      =
        (NODE_COUNT_RESET > MAX_NODES_COUNT) ? MAX_NODES_COUNT : NODE_COUNT_RESET;

    // action codes
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1);

    // input word
    typedef struct packed {
        logic                   action;
        logic [VERTEX_BITS-1:0] first_vertex;
        logic [VERTEX_BITS-1:0] second_vertex;
        logic [COST_BITS-1:0]   edge_cost;
    } msc_in_t;

    // result word
    typedef struct packed {
        logic                  merged;
        logic                  finished;
        logic [COST_BITS-1:0]  spacing;
        logic [COUNT_BITS-1:0] clusters_left;
        logic                  bad_vertex;
    } msc_out_t;

    // one forest entry as stored in the node memory
    typedef struct packed {
        logic [SIZE_BITS-1:0] tree_size;
        logic [NODE_BITS-1:0] parent_link;
    } msc_node_t;

    // configuration seen by the engine
    typedef struct packed {
        logic [COUNT_BITS-1:0] nodes_in_use;
        logic [COUNT_BITS-1:0] target_clusters;
    } msc_cfg_t;

endpackage

// ----- hw/rtl/max_spacing_cluster_union_find_top.sv -----
// Max-spacing k-clustering over a union-find forest held in one node memory.
// Input channel s_valid/s_ready/s_word takes one word at a time: a clear word
// rebuilds the forest, an edge word (edges in nondecreasing cost) tries one merge.
// Each word yields one result word on m_valid/m_ready/m_word.
// Configuration: cfg_we with cfg_index/cfg_wdata writes node_count (index 0) or
// target_clusters (index 1); write only while the block is idle.
// Sequence, from acceptance to the result register:
//   edge word: a walk from the first vertex to its root, then one from the
//     second vertex to its root, then ST_LINK and ST_GROW when it merges;
//     union by size keeps each tree depth at most 10; the walks read the
//     node memory one link per cycle. Bad vertex or finished run: straight
//   to ST_RESULT. Clear word: the whole node memory, one entry written per cycle.
// One word is in flight at a time; s_ready is high only between words.
// Reset (aresetn low, synchronous) runs the same clearing pass with
// s_ready low and no result; configuration returns to 1024 nodes and k = 4.
// A stalled receiver holds the result in the output register; the next word
// can be accepted and worked on meanwhile, and its result waits for that slot.
// depends on msc_pkg, msc_cfg, msc_engine
module max_spacing_cluster_union_find_top
    import msc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  msc_in_t                   s_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output msc_out_t                  m_word
);

    msc_cfg_t cfg;

    // configuration registers
    msc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // forest sequencer and node memory
    msc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// ----- hw/rtl/msc_ram.sv -----
// msc_ram: generic single-write, single-read memory with registered read data
// stand-alone, no package use
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/msc_cfg.sv -----
// msc_cfg: configuration registers and the clipped node count
// depends on msc_pkg
module msc_cfg
    import msc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output msc_cfg_t                  cfg
);

    logic [COUNT_BITS-1:0] node_count_reg;
    logic [COUNT_BITS-1:0] target_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RESET;
            target_reg     <= TARGET_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NODE_COUNT:      node_count_reg <= cfg_wdata;
                REG_TARGET_CLUSTERS: target_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // node count saturates at the memory depth
    always_comb begin
        cfg.nodes_in_use    = (node_count_reg > MAX_NODES_COUNT) ? MAX_NODES_COUNT
                                                                 : node_count_reg;
        cfg.target_clusters = target_reg;
    end

endmodule

// ----- hw/rtl/msc_engine.sv -----
// msc_engine: sequencer for clearing, root walks and linking over the node memory
// depends on msc_pkg and msc_ram
module msc_engine
    import msc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  msc_cfg_t cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  msc_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output msc_out_t m_word
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_WALK_A = 7'b0000100,
        ST_WALK_B = 7'b0001000,
        ST_LINK   = 7'b0010000,
        ST_GROW   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    msc_in_t               item_reg;
    logic                  bad_reg;
    logic                  merged_reg;
    logic                  emit_reg;
    logic [NODE_BITS-1:0]  sweep_reg;
    logic [NODE_BITS-1:0]  cur_reg;
    logic [NODE_BITS-1:0]  root_a_reg;
    logic [NODE_BITS-1:0]  root_b_reg;
    logic [SIZE_BITS-1:0]  size_a_reg;
    logic [SIZE_BITS-1:0]  size_b_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  done_reg;
    logic [COST_BITS-1:0]  held_reg;
    logic                  out_valid_reg;
    msc_out_t              out_reg;

    logic                  ram_we;
    logic [NODE_BITS-1:0]  ram_waddr;
    msc_node_t             ram_wdata;
    logic [NODE_BITS-1:0]  ram_raddr;
    msc_node_t             ram_rdata;

    logic                  accept;
    logic                  at_root;
    logic                  edge_bad;
    logic                  a_wins;
    logic [NODE_BITS-1:0]  winner;
    logic [NODE_BITS-1:0]  loser;
    logic [SIZE_BITS-1:0]  loser_size;
    logic [COUNT_BITS-1:0] count_dec;
    logic                  hit_target;
    logic                  out_load;

    msc_ram #(
        .WIDTH($bits(msc_node_t)),
        .DEPTH(MAX_NODES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign at_root  = (ram_rdata.parent_link == cur_reg);
    assign edge_bad = ({1'b0, s_word.first_vertex} >= cfg.nodes_in_use)
                   || ({1'b0, s_word.second_vertex} >= cfg.nodes_in_use);

    // larger tree wins; on a tie the first root goes under the second
    assign a_wins     = (size_a_reg > size_b_reg);
    assign winner     = a_wins ? root_a_reg : root_b_reg;
    assign loser      = a_wins ? root_b_reg : root_a_reg;
    assign loser_size = a_wins ? size_b_reg : size_a_reg;

    // saturating decrement and finish test
    assign count_dec  = (count_reg == '0) ? '0 : count_reg - COUNT_BITS'(1);
    assign hit_target = (({1'b0, count_dec} + (COUNT_BITS + 1)'(1))
                         == {1'b0, cfg.target_clusters});

    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || m_ready);

    // memory read address: next link of the walk
    always_comb begin
        case (state_reg)
            ST_IDLE:   ram_raddr = NODE_BITS'(s_word.first_vertex);
            ST_WALK_A: ram_raddr = at_root ? NODE_BITS'(item_reg.second_vertex)
                                           : ram_rdata.parent_link;
            ST_WALK_B: ram_raddr = ram_rdata.parent_link;
            default:   ram_raddr = cur_reg;
        endcase
    end

    // memory write: clearing pass, loser link, winner size
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = '{tree_size: SIZE_ONE, parent_link: sweep_reg};
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = loser;
                ram_wdata = '{tree_size: loser_size, parent_link: winner};
            end
            ST_GROW: begin
                ram_we    = 1'b1;
                ram_waddr = winner;
                ram_wdata = '{tree_size: size_a_reg + size_b_reg, parent_link: winner};
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sweep_reg == NODE_BITS'(MAX_NODES - 1)) begin
                    state_next = emit_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_word.action == ACT_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (edge_bad || done_reg) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_WALK_A;
                    end
                end
            end
            ST_WALK_A: begin
                if (at_root) begin
                    state_next = ST_WALK_B;
                end
            end
            ST_WALK_B: begin
                if (at_root) begin
                    state_next = (cur_reg == root_a_reg) ? ST_RESULT : ST_LINK;
                end
            end
            ST_LINK:   state_next = ST_GROW;
            ST_GROW:   state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            emit_reg      <= 1'b0;
            count_reg     <= COUNT_RESET;
            done_reg      <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_CLEAR: begin
                    sweep_reg <= sweep_reg + NODE_BITS'(1);
                end
                ST_IDLE: begin
                    if (accept && (s_word.action == ACT_CLEAR)) begin
                        sweep_reg <= '0;
                        emit_reg  <= 1'b1;
                        count_reg <= cfg.nodes_in_use;
                        done_reg  <= 1'b0;
                        held_reg  <= '0;
                    end
                end
                ST_LINK: begin
                    count_reg <= count_dec;
                    if (hit_target) begin
                        done_reg <= 1'b1;
                        held_reg <= item_reg.edge_cost;
                    end
                end
                default: ;
            endcase
            // output register
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_reg   <= s_word;
                    bad_reg    <= (s_word.action == ACT_EDGE) && edge_bad;
                    merged_reg <= 1'b0;
                    cur_reg    <= NODE_BITS'(s_word.first_vertex);
                end
            end
            ST_WALK_A: begin
                if (at_root) begin
                    root_a_reg <= cur_reg;
                    size_a_reg <= ram_rdata.tree_size;
                    cur_reg    <= NODE_BITS'(item_reg.second_vertex);
                end else begin
                    cur_reg <= ram_rdata.parent_link;
                end
            end
            ST_WALK_B: begin
                if (at_root) begin
                    root_b_reg <= cur_reg;
                    size_b_reg <= ram_rdata.tree_size;
                end else begin
                    cur_reg <= ram_rdata.parent_link;
                end
            end
            ST_LINK: begin
                merged_reg <= 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            out_reg.merged        <= merged_reg;
            out_reg.finished      <= done_reg;
            out_reg.spacing       <= done_reg ? held_reg : '0;
            out_reg.clusters_left <= count_reg;
            out_reg.bad_vertex    <= bad_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

endmodule

// ----- hw/rtl/msc_checker.sv -----
// msc_checker: port-level assertions for the clustering block, bound to the top
// depends on msc_pkg and max_spacing_cluster_union_find_top
module msc_checker
    import msc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input msc_out_t m_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // one word in flight: no acceptance right after another
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // reset starts the clearing pass with input closed
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open right after reset");

    // spacing shows only once the run has finished
    a_spacing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.finished |-> m_word.spacing == '0)
        else $error("spacing nonzero before finish");

    // an ignored edge never merges
    a_bad_no_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.bad_vertex |-> !m_word.merged)
        else $error("bad vertex edge reported a merge");

endmodule

bind max_spacing_cluster_union_find_top msc_checker u_msc_checker (.*);
